// ----- rtl/alawjb_pkg.sv -----
// ----------------------------------------------------------------------------
// alawjb_pkg
// Shared widths, codes and the A-law expansion for the jitter buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alawjb_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int VOL_W      = 7;
  localparam int THR_W      = 10;
  localparam int FILL_W     = 10;
  localparam int BYTE_W     = 8;
  localparam int FCOUNT_W   = 7;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME          = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD = 1'b1;

  // input commands and result kinds
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_READ   = 1'b1;
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // reset values of the configuration registers, and the underrun count ceiling
  localparam logic [VOL_W-1:0] VOL_MAX       = 7'd100;
  localparam logic [THR_W-1:0] THR_DEFAULT   = 10'd160;
  localparam logic [COUNT_W-1:0] UNDERRUN_MAX = 16'hFFFF;

  // volume scaling: divide by 100 through a reciprocal multiply
  localparam int DIV_BASE    = 100;
  localparam int MAG_W       = 22;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_K = 26'd42949672;

  // output saturation bounds
  localparam logic signed [SAMPLE_W:0] SAT_HI = 17'sd32767;
  localparam logic signed [SAMPLE_W:0] SAT_LO = -17'sd32768;

  // G.711 A-law code to 16-bit linear PCM
  function automatic logic signed [SAMPLE_W-1:0] alaw_expand(input logic [BYTE_W-1:0] code);
    logic [BYTE_W-1:0]   a;
    logic [SAMPLE_W-1:0] mag;
    logic [2:0]          seg;
    a   = code ^ 8'h55;
    seg = a[6:4];
    mag = {8'd0, a[3:0], 4'd0};
    if (seg == 3'd0) begin
      mag = mag + 16'd8;
    end else begin
      mag = (mag + 16'h0108) << (seg - 3'd1);
    end
    return a[7] ? $signed(mag) : -$signed(mag);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/alawjb_ring.sv -----
// ----------------------------------------------------------------------------
// alawjb_ring
// Sample ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alawjb_ring #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [ADDR_W-1:0]             wr_addr,
  input  wire logic [alawjb_pkg::SAMPLE_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0]             rd_addr,
  output logic      [alawjb_pkg::SAMPLE_W-1:0] rd_data
);
  import alawjb_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  // write one slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read every cycle, data registered for the next cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/alawjb_scale.sv -----
// ----------------------------------------------------------------------------
// alawjb_scale
// Three-stage volume scaler: sample * volume / 100, truncated toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alawjb_scale (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  input  wire logic signed [alawjb_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic        [alawjb_pkg::VOL_W-1:0]    in_volume,
  output logic                                      out_valid,
  output logic signed      [alawjb_pkg::SAMPLE_W-1:0] out_sample
);
  import alawjb_pkg::*;

  localparam int PROD_W = SAMPLE_W + VOL_W + 1;
  localparam int PK_W   = MAG_W + RECIP_W;

  logic                       v1_r, v2_r, v3_r;
  logic                       neg1_r, neg2_r;
  logic [MAG_W-1:0]           mag1_r, mag2_r;
  logic [SAMPLE_W-1:0]        q0_r;
  logic signed [SAMPLE_W-1:0] res_r;

  logic signed [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]          prod_abs;
  logic [PK_W-1:0]            pk;
  logic [MAG_W-1:0]           rem;
  logic [SAMPLE_W-1:0]        q_fix;
  logic signed [SAMPLE_W:0]   q_sgn;
  logic signed [SAMPLE_W-1:0] q_sat;

  always_comb begin
    // stage 1: gain product and magnitude
    prod     = PROD_W'(in_sample) * PROD_W'($signed({1'b0, in_volume}));
    prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    // stage 2: estimate of magnitude / 100, low by at most one
    pk       = PK_W'(mag1_r) * PK_W'(RECIP_K);
    // stage 3: correct the estimate, restore sign, clamp
    rem      = mag2_r - MAG_W'(q0_r * DIV_BASE);
    q_fix    = (rem >= MAG_W'(DIV_BASE)) ? q0_r + 1'b1 : q0_r;
    q_sgn    = neg2_r ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
    priority if (q_sgn > SAT_HI) begin
      q_sat = SAT_HI[SAMPLE_W-1:0];
    end else if (q_sgn < SAT_LO) begin
      q_sat = SAT_LO[SAMPLE_W-1:0];
    end else begin
      q_sat = q_sgn[SAMPLE_W-1:0];
    end
  end

  // advance the valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // hold stage data; the result stays until the next sample arrives
  always_ff @(posedge clk) begin
    if (in_valid) begin
      neg1_r <= prod[PROD_W-1];
      mag1_r <= prod_abs[MAG_W-1:0];
    end
    if (v1_r) begin
      neg2_r <= neg1_r;
      mag2_r <= mag1_r;
      q0_r   <= pk[RECIP_SHIFT +: SAMPLE_W];
    end
    if (v2_r) begin
      res_r <= q_sat;
    end
  end

  assign out_valid  = v3_r;
  assign out_sample = res_r;

endmodule

`default_nettype wire

// ----- rtl/alaw_jitter_buffer_upsampler_top.sv -----
// ----------------------------------------------------------------------------
// alaw_jitter_buffer_upsampler_top
// A-law jitter buffer with 2x linear upsampling and volume control.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries write items (one A-law byte)
//   and read items (a batch of 16 kHz frames). Result channel (out_valid /
//   out_stall) returns one acknowledgment per write item and one beat per
//   frame of a read batch. Configuration writes (volume, start threshold)
//   go through cfg_wr_en / cfg_index / cfg_wdata while the block is idle.
// Sequencing:
//   A write item is acknowledged from ST_WR once the output register is free;
//   only then does the block return to idle and take the next item. A read
//   batch that plays starts in ST_RQ, then each frame passes ST_MS and ST_SC,
//   paced by the ring read plus the three-stage volume scaler. A silent batch
//   gives one frame per cycle while the output register is free. The next item
//   is taken in the cycle after a batch's last beat enters the output register.
// Reset:
//   Pointers, playback flag, underrun count and registers return to their
//   defaults. The ring is not swept: a slot never written since reset reads
//   as zero, tracked by the write pointer and a wrap flag.
// Stall:
//   A stalled beat is held in the output register; the next item may still
//   be accepted meanwhile, and frame production pauses until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alaw_jitter_buffer_upsampler_top #(
  parameter int RING_DEPTH = 1024,
  parameter int MAX_FRAMES = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_command,
  input  wire logic        [alawjb_pkg::BYTE_W-1:0]     in_alaw_byte,
  input  wire logic                                   in_burst_end,
  input  wire logic        [alawjb_pkg::FCOUNT_W-1:0]   in_frame_count,
  // result channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_result_kind,
  output logic                                        out_write_accepted,
  output logic signed      [alawjb_pkg::SAMPLE_W-1:0]   out_left_sample,
  output logic signed      [alawjb_pkg::SAMPLE_W-1:0]   out_right_sample,
  output logic                                        out_last_frame,
  output logic                                        out_underrun,
  output logic             [alawjb_pkg::FILL_W-1:0]     out_fill_level,
  output logic             [alawjb_pkg::COUNT_W-1:0]    out_underrun_total,
  // configuration port
  input  wire logic                                   cfg_wr_en,
  input  wire logic        [alawjb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [alawjb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import alawjb_pkg::*;

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int FCW = $clog2(MAX_FRAMES + 1);
  localparam int CW  = (PW > THR_W) ? PW : THR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_RQ,
    ST_SIL,
    ST_MS,
    ST_SC,
    ST_EMIT
  } state_t;

  state_t                     state_r;
  logic [BYTE_W-1:0]          byte_r;
  logic                       burst_r;
  logic [FCW-1:0]             n_r;
  logic [FCW-1:0]             fidx_r;
  logic                       under_r;
  logic [PW-1:0]              base_r;
  logic [PW-1:0]              wp_r;
  logic [PW-1:0]              rp_r;
  logic                       wrapped_r;
  logic                       playing_r;
  logic [COUNT_W-1:0]         urun_cnt_r;
  logic [VOL_W-1:0]           vol_r;
  logic [THR_W-1:0]           thr_r;
  logic                       sv_r;
  logic signed [SAMPLE_W-1:0] prev_r;

  logic                       out_valid_r;
  logic                       out_kind_r;
  logic                       out_acc_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;
  logic                       out_under_r;
  logic [FILL_W-1:0]          out_fill_r;
  logic [COUNT_W-1:0]         out_total_r;

  logic                       out_free;
  logic                       out_load;
  logic [PW:0]                fill_wide;
  logic [PW-1:0]              fill;
  logic                       full;
  logic [PW-1:0]              wp_nxt;
  logic [PW-1:0]              fill_nxt;
  logic [CW-1:0]              fill_nxt_ext;
  logic [CW-1:0]              fill_ext;
  logic                       start_play;
  logic [FCW-1:0]             needed;
  logic                       short_fill;
  logic [PW:0]                rp_sum;
  logic [PW-1:0]              rp_nxt;
  logic [FCW-1:0]             rd_idx;
  logic [FCW-1:0]             rd_off;
  logic [PW-1:0]              rd_base;
  logic [PW:0]                rd_sum;
  logic [PW-1:0]              rd_addr;
  logic                       ring_we;
  logic [SAMPLE_W-1:0]        ring_q;
  logic signed [SAMPLE_W-1:0] slot_s;
  logic signed [SAMPLE_W:0]   avg_sum;
  logic signed [SAMPLE_W:0]   avg_adj;
  logic signed [SAMPLE_W-1:0] frame_s;
  logic                       scale_done;
  logic signed [SAMPLE_W-1:0] scaled_s;
  logic                       frame_emit;
  logic                       frame_last;
  logic [FCW-1:0]             n_clamp;
  logic signed [SAMPLE_W-1:0] ack_dec;

  always_comb begin
    out_free = !out_valid_r || !out_stall;

    // fill level and write-side next values
    fill_wide    = {1'b0, wp_r} + ((wp_r < rp_r) ? (PW+1)'(RING_DEPTH) : '0) - {1'b0, rp_r};
    fill         = fill_wide[PW-1:0];
    fill_ext     = CW'(fill);
    full         = (fill == PW'(RING_DEPTH - 1));
    wp_nxt       = full ? wp_r : ((wp_r == PW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1);
    fill_nxt     = full ? fill : fill + 1'b1;
    fill_nxt_ext = CW'(fill_nxt);
    start_play   = burst_r && !playing_r && (fill_nxt_ext >= CW'(thr_r));
    ack_dec      = alaw_expand(byte_r);

    // read batch sizing
    n_clamp    = (in_frame_count > FCOUNT_W'(MAX_FRAMES)) ? FCW'(MAX_FRAMES)
                                                          : FCW'(in_frame_count);
    needed     = (n_r >> 1) + FCW'(n_r[0]);
    short_fill = fill_ext < CW'(needed);
    rp_sum     = {1'b0, rp_r} + (PW+1)'(needed);
    rp_nxt     = (rp_sum >= (PW+1)'(RING_DEPTH)) ? PW'(rp_sum - (PW+1)'(RING_DEPTH))
                                                 : rp_sum[PW-1:0];

    // frame sequencing
    frame_last = (fidx_r == n_r - 1'b1);
    frame_emit = (((state_r == ST_SC) && scale_done) || (state_r == ST_EMIT)) && out_free;

    // load the output register with an acknowledgment or a frame
    out_load = (((state_r == ST_WR) || (state_r == ST_SIL)) && out_free) || frame_emit;

    // slot for the next frame: even frames take their own sample, odd the one after
    rd_idx  = (state_r == ST_RQ) ? '0 : fidx_r + 1'b1;
    rd_off  = (rd_idx >> 1) + FCW'(rd_idx[0]);
    rd_base = (state_r == ST_RQ) ? rp_r : base_r;
    rd_sum  = {1'b0, rd_base} + (PW+1)'(rd_off);
    rd_addr = (rd_sum >= (PW+1)'(RING_DEPTH)) ? PW'(rd_sum - (PW+1)'(RING_DEPTH))
                                              : rd_sum[PW-1:0];

    ring_we = (state_r == ST_WR) && out_free && !full;

    // even frame passes the slot, odd frame averages toward zero
    slot_s  = sv_r ? $signed(ring_q) : '0;
    avg_sum = (SAMPLE_W+1)'(prev_r) + (SAMPLE_W+1)'(slot_s);
    avg_adj = avg_sum + $signed({{SAMPLE_W{1'b0}}, avg_sum[SAMPLE_W]});
    frame_s = fidx_r[0] ? $signed(avg_adj[SAMPLE_W:1]) : slot_s;
  end

  assign in_stall = (state_r != ST_IDLE);

  alawjb_ring #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (PW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (wp_r),
    .wr_data (ack_dec),
    .rd_addr (rd_addr),
    .rd_data (ring_q)
  );

  alawjb_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (state_r == ST_MS),
    .in_sample  (frame_s),
    .in_volume  (vol_r),
    .out_valid  (scale_done),
    .out_sample (scaled_s)
  );

  // mark whether the slot being read was ever written since reset
  always_ff @(posedge clk) begin
    sv_r <= wrapped_r || (rd_addr < wp_r);
  end

  // sequencer, ring pointers, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      wrapped_r   <= 1'b0;
      playing_r   <= 1'b0;
      urun_cnt_r  <= '0;
      vol_r       <= VOL_MAX;
      thr_r       <= THR_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      // load a new beat, or drop one once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end

      // configuration writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_VOLUME: begin
            vol_r <= (cfg_wdata[VOL_W-1:0] > VOL_MAX) ? VOL_MAX : cfg_wdata[VOL_W-1:0];
          end
          REG_START_THRESHOLD: begin
            thr_r <= cfg_wdata[THR_W-1:0];
          end
          default: begin
          end
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            byte_r  <= in_alaw_byte;
            burst_r <= in_burst_end;
            n_r     <= n_clamp;
            state_r <= (in_command == CMD_WRITE) ? ST_WR : ST_RQ;
          end
        end

        ST_WR: begin
          if (out_free) begin
            wp_r <= wp_nxt;
            if (!full && (wp_r == PW'(RING_DEPTH - 1))) begin
              wrapped_r <= 1'b1;
            end
            if (start_play) begin
              playing_r <= 1'b1;
            end
            out_kind_r   <= KIND_ACK;
            out_acc_r    <= !full;
            out_sample_r <= '0;
            out_last_r   <= 1'b1;
            out_under_r  <= 1'b0;
            out_fill_r   <= fill_nxt_ext[FILL_W-1:0];
            out_total_r  <= urun_cnt_r;
            state_r      <= ST_IDLE;
          end
        end

        ST_RQ: begin
          fidx_r <= '0;
          priority if (n_r == '0) begin
            state_r <= ST_IDLE;
          end else if (!playing_r) begin
            under_r <= 1'b0;
            state_r <= ST_SIL;
          end else if (short_fill) begin
            under_r   <= 1'b1;
            playing_r <= 1'b0;
            if (urun_cnt_r != UNDERRUN_MAX) begin
              urun_cnt_r <= urun_cnt_r + 1'b1;
            end
            state_r <= ST_SIL;
          end else begin
            base_r  <= rp_r;
            rp_r    <= rp_nxt;
            state_r <= ST_MS;
          end
        end

        ST_SIL: begin
          if (out_free) begin
            out_kind_r   <= KIND_FRAME;
            out_acc_r    <= 1'b0;
            out_sample_r <= '0;
            out_last_r   <= frame_last;
            out_under_r  <= under_r;
            out_fill_r   <= fill_ext[FILL_W-1:0];
            out_total_r  <= urun_cnt_r;
            fidx_r       <= fidx_r + 1'b1;
            if (frame_last) begin
              state_r <= ST_IDLE;
            end
          end
        end

        ST_MS: begin
          if (!fidx_r[0]) begin
            prev_r <= slot_s;
          end
          state_r <= ST_SC;
        end

        ST_SC, ST_EMIT: begin
          if (frame_emit) begin
            out_kind_r   <= KIND_FRAME;
            out_acc_r    <= 1'b0;
            out_sample_r <= scaled_s;
            out_last_r   <= frame_last;
            out_under_r  <= 1'b0;
            out_fill_r   <= fill_ext[FILL_W-1:0];
            out_total_r  <= urun_cnt_r;
            fidx_r       <= fidx_r + 1'b1;
            state_r      <= frame_last ? ST_IDLE : ST_MS;
          end else if (scale_done) begin
            state_r <= ST_EMIT;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_write_accepted = out_acc_r;
  assign out_left_sample    = out_sample_r;
  assign out_right_sample   = out_sample_r;
  assign out_last_frame     = out_last_r;
  assign out_underrun       = out_under_r;
  assign out_fill_level     = out_fill_r;
  assign out_underrun_total = out_total_r;

endmodule

`default_nettype wire

// ----- rtl/alawjb_checker.sv -----
// ----------------------------------------------------------------------------
// alawjb_checker
// Port-level checks on the result channel of the jitter buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alawjb_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic                                 out_result_kind,
  input wire logic                                 out_write_accepted,
  input wire logic signed [alawjb_pkg::SAMPLE_W-1:0] out_left_sample,
  input wire logic signed [alawjb_pkg::SAMPLE_W-1:0] out_right_sample,
  input wire logic                                 out_last_frame,
  input wire logic                                 out_underrun
);
  import alawjb_pkg::*;

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // an acknowledgment is a single, silent, closing beat
  a_ack_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_ACK) |->
      out_last_frame && !out_underrun && (out_left_sample == '0) && (out_right_sample == '0))
    else $error("malformed write acknowledgment");

  // an audio frame carries one value on both channels and no write status
  a_frame_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_FRAME) |->
      !out_write_accepted && (out_left_sample == out_right_sample))
    else $error("malformed audio frame");

  // an underrun batch is silent
  a_underrun_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_underrun |-> (out_left_sample == '0))
    else $error("underrun frame is not silent");

endmodule

bind alaw_jitter_buffer_upsampler_top alawjb_checker u_alawjb_checker (.*);

`default_nettype wire

// ----- tb/tb_alaw_jitter_buffer_upsampler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alaw_jitter_buffer_upsampler_top
// Self-checking bench for the A-law jitter buffer with 2x upsampling. A
// behavioral copy of the buffer predicts every acknowledgment and frame
// beat. A checker compares each beat, field by field, in order. Directed
// tests cover codes, silence, volume, thresholds and a shortage.
// Random write bursts and reads then run under three stall/gap profiles.
// ----------------------------------------------------------------------------

module tb_alaw_jitter_buffer_upsampler_top;
  import alawjb_pkg::*;

  localparam int RING_SLOTS    = 1024;
  localparam int FRAME_CAP     = 64;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic                       kind;
    logic                       accepted;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       underrun;
    logic [FILL_W-1:0]          fill;
    logic [COUNT_W-1:0]         total;
  } beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = CMD_WRITE;
  logic [BYTE_W-1:0]     in_alaw_byte = '0;
  logic                  in_burst_end = 1'b0;
  logic [FCOUNT_W-1:0]   in_frame_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_result_kind;
  logic                  out_write_accepted;
  logic signed [SAMPLE_W-1:0] out_left_sample;
  logic signed [SAMPLE_W-1:0] out_right_sample;
  logic                  out_last_frame;
  logic                  out_underrun;
  logic [FILL_W-1:0]     out_fill_level;
  logic [COUNT_W-1:0]    out_underrun_total;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_VOLUME;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // buffer state as the bench sees it
  logic [SAMPLE_W-1:0] pcm_ring [RING_SLOTS];
  logic [FILL_W-1:0]   wr_ptr;
  logic [FILL_W-1:0]   rd_ptr;
  logic                playing;
  int                  prev_pcm;
  logic [COUNT_W-1:0]  underrun_cnt;
  int                  gain_pct;
  int                  start_level;

  beat_t expected_beats[$];

  int err_count      = 0;
  int items_sent     = 0;
  int beats_checked  = 0;
  int shortage_count = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;

  alaw_jitter_buffer_upsampler_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_alaw_byte       (in_alaw_byte),
    .in_burst_end       (in_burst_end),
    .in_frame_count     (in_frame_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_write_accepted (out_write_accepted),
    .out_left_sample    (out_left_sample),
    .out_right_sample   (out_right_sample),
    .out_last_frame     (out_last_frame),
    .out_underrun       (out_underrun),
    .out_fill_level     (out_fill_level),
    .out_underrun_total (out_underrun_total),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // G.711 A-law expansion: magnitude is (2m+1)<<3 in the first segment,
  // (2m+33)<<(seg+2) above it
  function automatic int alaw_to_pcm(logic [BYTE_W-1:0] code);
    logic [BYTE_W-1:0] t;
    int mant;
    int seg;
    int mag;
    t    = code ^ 8'h55;
    mant = t[3:0];
    seg  = t[6:4];
    if (seg == 0) mag = (2 * mant + 1) << 3;
    else mag = (2 * mant + 33) << (seg + 2);
    return t[7] ? mag : -mag;
  endfunction

  function automatic int ring_at(logic [FILL_W-1:0] idx);
    return int'($signed(pcm_ring[idx]));
  endfunction

  function automatic void push_beat(logic kind, logic acc, int s, logic last, logic und);
    beat_t b;
    b.kind     = kind;
    b.accepted = acc;
    b.sample   = s[SAMPLE_W-1:0];
    b.last     = last;
    b.underrun = und;
    b.fill     = wr_ptr - rd_ptr;
    b.total    = underrun_cnt;
    expected_beats.push_back(b);
  endfunction

  // Store the byte unless the ring is full, then run the start check
  function automatic void predict_write(logic [BYTE_W-1:0] code, logic burst_end);
    logic              acc;
    logic [FILL_W-1:0] lvl;
    acc = 1'b0;
    lvl = wr_ptr - rd_ptr;
    if (lvl < RING_SLOTS - 1) begin
      pcm_ring[wr_ptr] = SAMPLE_W'(alaw_to_pcm(code));
      wr_ptr = wr_ptr + 1'b1;
      acc = 1'b1;
    end
    lvl = wr_ptr - rd_ptr;
    if (burst_end && !playing && lvl >= start_level) playing = 1'b1;
    push_beat(KIND_ACK, acc, 0, 1'b1, 1'b0);
  endfunction

  // Produce a batch of frames: silence, or stored samples with midpoints
  function automatic void predict_read(logic [FCOUNT_W-1:0] cnt);
    int                n;
    int                need;
    int                s;
    int                frames[FRAME_CAP];
    logic              silent;
    logic              und;
    logic [FILL_W-1:0] lvl;
    logic [FILL_W-1:0] base;
    n = cnt;
    if (n > FRAME_CAP) n = FRAME_CAP;
    if (n == 0) return;
    need   = (n + 1) / 2;
    lvl    = wr_ptr - rd_ptr;
    silent = !playing;
    und    = 1'b0;
    if (playing && lvl < need) begin
      silent  = 1'b1;
      und     = 1'b1;
      playing = 1'b0;
      shortage_count++;
      if (underrun_cnt != UNDERRUN_MAX) underrun_cnt = underrun_cnt + 1'b1;
    end
    if (silent) begin
      for (int i = 0; i < n; i++) push_beat(KIND_FRAME, 1'b0, 0, i == n - 1, und);
      return;
    end
    base = rd_ptr;
    for (int i = 0; i < n; i++) begin
      if (i % 2 == 0) begin
        s = ring_at(base + i / 2);
        prev_pcm = s;
      end else begin
        s = (prev_pcm + ring_at(base + i / 2 + 1)) / 2;
      end
      s = s * gain_pct / 100;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      frames[i] = s;
    end
    rd_ptr = base + need;
    for (int i = 0; i < n; i++) push_beat(KIND_FRAME, 1'b0, frames[i], i == n - 1, 1'b0);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= 40) begin
      $display("ERROR beat %0d: %s got %0d, expected %0d", beats_checked, what, got, want);
    end
  endtask

  // Compare every accepted result beat against the oldest prediction
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("beat with none pending, kind", out_result_kind, -1);
      end else begin
        want = expected_beats.pop_front();
        if (out_result_kind !== want.kind)
          report_mismatch("result_kind", out_result_kind, want.kind);
        if (out_write_accepted !== want.accepted)
          report_mismatch("write_accepted", out_write_accepted, want.accepted);
        if (out_left_sample !== want.sample)
          report_mismatch("left_sample", int'(out_left_sample), int'(want.sample));
        if (out_right_sample !== want.sample)
          report_mismatch("right_sample", int'(out_right_sample), int'(want.sample));
        if (out_last_frame !== want.last)
          report_mismatch("last_frame", out_last_frame, want.last);
        if (out_underrun !== want.underrun)
          report_mismatch("underrun", out_underrun, want.underrun);
        if (out_fill_level !== want.fill)
          report_mismatch("fill_level", out_fill_level, want.fill);
        if (out_underrun_total !== want.total)
          report_mismatch("underrun_total", out_underrun_total, want.total);
        beats_checked++;
      end
    end
  end

  // Present one item, optionally after a gap, and hold it until accepted
  task automatic send_item(logic cmd, logic [BYTE_W-1:0] code, logic burst_end,
                           logic [FCOUNT_W-1:0] cnt);
    int gap;
    @(negedge clk);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_alaw_byte   <= code;
    in_burst_end   <= burst_end;
    in_frame_count <= cnt;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (cmd == CMD_WRITE) predict_write(code, burst_end);
    else predict_read(cnt);
  endtask

  task automatic send_write(logic [BYTE_W-1:0] code, logic burst_end);
    send_item(CMD_WRITE, code, burst_end, FCOUNT_W'($urandom));
  endtask

  task automatic send_read(logic [FCOUNT_W-1:0] cnt);
    send_item(CMD_READ, BYTE_W'($urandom), 1'($urandom), cnt);
  endtask

  // Drop valid, wait for every pending beat, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_VOLUME) gain_pct = (data[6:0] > 100) ? 100 : int'(data[6:0]);
    else start_level = data;
  endtask

  // Reads before any playback: silence, including zero and oversized counts
  task automatic test_silent_reads();
    send_read(7'd1);
    send_read(7'd64);
    send_read(7'd127);
    send_read(7'd0);
    wait_drained();
  endtask

  // Code extremes and segment edges; the default threshold blocks the start
  task automatic test_alaw_codes();
    logic [BYTE_W-1:0] codes[8];
    codes = '{8'h00, 8'hFF, 8'h55, 8'hD5, 8'h2A, 8'hAA, 8'h80, 8'h7F};
    foreach (codes[i]) send_write(codes[i], i == 7);
  endtask

  // Zero threshold start, odd and even batches, read past the written
  // slots, then a shortage
  task automatic test_playback();
    wait_drained();
    write_reg(REG_START_THRESHOLD, '0);
    send_write(8'h33, 1'b1);
    send_read(7'd3);
    send_read(7'd4);
    send_read(7'd10);
    send_read(7'd1);
  endtask

  // Mute, half and over-range gain, each with an even batch
  task automatic test_volume_steps();
    logic [CFG_DATA_W-1:0] gains[3];
    gains = '{10'd0, 10'd50, 10'h3FF};
    foreach (gains[i]) begin
      wait_drained();
      write_reg(REG_VOLUME, gains[i]);
      send_write(BYTE_W'($urandom), 1'b0);
      send_write(BYTE_W'($urandom), 1'b1);
      send_read(7'd4);
    end
  endtask

  // Mostly bursts closed by an end mark, reads of any size, some noise
  task automatic random_phase(int budget);
    int left;
    int burst;
    int pick;
    left = budget;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        burst = $urandom_range(12, 1);
        for (int k = 0; k < burst; k++)
          send_write(BYTE_W'($urandom), (k == burst - 1) && (pick >= 6));
        left -= burst;
      end else if (pick < 92) begin
        send_read(FCOUNT_W'($urandom_range(64, 1)));
        left--;
      end else if (pick < 97) begin
        send_read(FCOUNT_W'($urandom_range(127, 0)));
        left--;
      end else begin
        send_write(BYTE_W'($urandom), 1'($urandom));
        left--;
      end
    end
  endtask

  task automatic next_phase(int gap_pct, int hold_pct, logic [CFG_DATA_W-1:0] thr);
    wait_drained();
    send_idle_pct = gap_pct;
    stall_pct     = hold_pct;
    write_reg(REG_VOLUME, CFG_DATA_W'($urandom_range(127)));
    write_reg(REG_START_THRESHOLD, thr);
  endtask

  initial begin
    foreach (pcm_ring[i]) pcm_ring[i] = '0;
    wr_ptr       = '0;
    rd_ptr       = '0;
    playing      = 1'b0;
    prev_pcm     = 0;
    underrun_cnt = '0;
    gain_pct     = VOL_MAX;
    start_level  = THR_DEFAULT;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 13;
    stall_pct     = 49;
    test_silent_reads();
    test_alaw_codes();
    test_playback();
    test_volume_steps();

    next_phase(13, 49, 10'd1);
    random_phase(78);
    next_phase(49, 13, CFG_DATA_W'($urandom_range(48, 1)));
    random_phase(78);
    next_phase(0, 0, CFG_DATA_W'($urandom_range(48, 1)));
    random_phase(78);

    wait_drained();

    $display("Ran %0d items and checked %0d beats across three stall profiles.",
             items_sent, beats_checked);
    $display("Saw %0d shortages; underrun count ended at %0d.", shortage_count, underrun_cnt);
    if (err_count == 0) begin
      $display("alaw_jitter_buffer_upsampler_top: match");
    end else begin
      $display("alaw_jitter_buffer_upsampler_top: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20_000_000;
    $display("alaw_jitter_buffer_upsampler_top: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/alawjb_pkg.sv
rtl/alawjb_ring.sv
rtl/alawjb_scale.sv
rtl/alaw_jitter_buffer_upsampler_top.sv
rtl/alawjb_checker.sv
tb/tb_alaw_jitter_buffer_upsampler_top.sv
